>>> hw/rtl/mono_framebuffer_remap_writer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mono framebuffer remap writer
// Shared property forms used by the RTL checks.
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_REMAP_WRITER_UNIT_MACROS_SVH
`define MONO_FRAMEBUFFER_REMAP_WRITER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define MFRW_ASSERT_NOW(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define MFRW_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/mfrw_pkg.sv
// ----------------------------------------------------------------------------
// mfrw_pkg
// Geometry, action codes and shared types of the mono framebuffer writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfrw_pkg;

	// panel geometry
	localparam int HORIZ_RES   = 400;
	localparam int VERT_RES    = 300;
	localparam int FRAME_BYTES = (HORIZ_RES * VERT_RES) / 8;
	localparam int ROW_BYTES   = VERT_RES / 4;
	localparam int MEM_AW      = $clog2(FRAME_BYTES);

	// fixed field widths
	localparam int COORD_W = 9;
	localparam int ADDR_W  = 14;
	localparam int DATA_W  = 8;
	localparam int ACT_W   = 3;

	// action codes
	localparam logic [ACT_W-1:0] ACT_SET_PIXEL = 3'd0;
	localparam logic [ACT_W-1:0] ACT_BEGIN_WIN = 3'd1;
	localparam logic [ACT_W-1:0] ACT_WIN_BYTE  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_FILL      = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ      = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_WIN_LEFT   = 2'd0;
	localparam logic [1:0] REG_WIN_TOP    = 2'd1;
	localparam logic [1:0] REG_WIN_RIGHT  = 2'd2;
	localparam logic [1:0] REG_WIN_BOTTOM = 2'd3;

	// pixel location as seen by the frame memory
	typedef struct packed {
		logic [MEM_AW-1:0] addr;
		logic [DATA_W-1:0] mask;
		logic              onscreen;
	} pix_t;

endpackage

>>> hw/rtl/mfrw_pix_unit.sv
// ----------------------------------------------------------------------------
// mfrw_pix_unit
// Shared pixel-to-byte mapper: registers byte address, bit mask, on-screen.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfrw_pix_unit (
	input  logic                         clk,
	input  logic                         load,
	input  logic [mfrw_pkg::COORD_W-1:0] x,
	input  logic [mfrw_pkg::COORD_W-1:0] y,
	output mfrw_pkg::pix_t               pix
);

	localparam int PROD_W = 16;

	logic [mfrw_pkg::COORD_W-1:0] inv_y;
	logic [PROD_W-1:0]            prod;
	logic [PROD_W-1:0]            idx;
	logic [2:0]                   bit_pos;
	logic                         on_scr;
	mfrw_pkg::pix_t               pix_q;

	// row inversion and landscape packing
	always_comb begin
		inv_y   = mfrw_pkg::COORD_W'(mfrw_pkg::VERT_RES - 1) - y;
		prod    = PROD_W'(x[mfrw_pkg::COORD_W-1:1]) * PROD_W'(mfrw_pkg::ROW_BYTES);
		idx     = prod + PROD_W'(inv_y[mfrw_pkg::COORD_W-1:2]);
		bit_pos = {inv_y[1:0], x[0]};
		on_scr  = ({1'b0, x} < (mfrw_pkg::COORD_W + 1)'(mfrw_pkg::HORIZ_RES)) &&
		          ({1'b0, y} < (mfrw_pkg::COORD_W + 1)'(mfrw_pkg::VERT_RES));
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pix_q.addr     <= idx[mfrw_pkg::MEM_AW-1:0];
			pix_q.mask     <= 8'h80 >> bit_pos;
			pix_q.onscreen <= on_scr;
		end
	end

	assign pix = pix_q;

endmodule

>>> hw/rtl/mono_framebuffer_remap_writer_unit.sv
// From accept to done: set pixel maps, then reads and writes if on-screen; read byte
// reads only in range; fill writes every byte; spare codes and an empty window finish
// directly; window byte maps each bit, stopping after eight or once the cursor passed.
// One item at a time; an on-screen bit costs mapper, read and write of its frame byte.
// Reset clears the sequencer, cursor and window registers; frame contents
// are undefined until the first fill. The receiver cannot stall done.
// ----------------------------------------------------------------------------
// mono_framebuffer_remap_writer_unit
// 1-bit frame memory in landscape packing with pixel, window, fill and read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mono_framebuffer_remap_writer_unit_macros.svh"

module mono_framebuffer_remap_writer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [mfrw_pkg::ACT_W-1:0]   action,
	input  logic [mfrw_pkg::COORD_W-1:0] col,
	input  logic [mfrw_pkg::COORD_W-1:0] row,
	input  logic [mfrw_pkg::DATA_W-1:0]  value,
	input  logic [mfrw_pkg::ADDR_W-1:0]  byte_addr,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [mfrw_pkg::COORD_W-1:0] cfg_wdata,
	output logic                         done,
	output logic [mfrw_pkg::DATA_W-1:0]  read_data,
	output logic                         window_done
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PIX  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_WR   = 3'd3;
	localparam logic [2:0] S_WBIT = 3'd4;
	localparam logic [2:0] S_FILL = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	localparam int AW = mfrw_pkg::MEM_AW;
	localparam int CW = mfrw_pkg::COORD_W;
	localparam int DW = mfrw_pkg::DATA_W;

	logic [2:0]                 state_q;
	logic [mfrw_pkg::ACT_W-1:0] act_q;
	logic [DW-1:0]              value_q;
	logic [DW-1:0]              shift_q;
	logic [AW-1:0]              raddr_q;
	logic                       rd_ok_q;
	logic                       on_q;
	logic [3:0]                 bit_cnt_q;
	logic [AW-1:0]              fill_cnt_q;
	logic [CW-1:0]              cur_col_q;
	logic [CW-1:0]              cur_row_q;
	logic                       passed_q;
	logic [CW-1:0]              win_left_q;
	logic [CW-1:0]              win_top_q;
	logic [CW-1:0]              win_right_q;
	logic [CW-1:0]              win_bottom_q;
	logic                       done_q;
	logic [DW-1:0]              read_data_q;
	logic                       window_done_q;

	logic                       accept;
	logic                       win_empty;
	logic                       pix_load;
	logic [CW-1:0]              pix_x;
	logic [CW-1:0]              pix_y;
	mfrw_pkg::pix_t             pix;
	logic [2:0]                 after_pix;

	logic [DW-1:0]              mem [mfrw_pkg::FRAME_BYTES];
	logic [DW-1:0]              rdata_q;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [DW-1:0]              mem_wdata;
	logic [AW-1:0]              mem_raddr;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign win_empty = (win_right_q < win_left_q) || (win_bottom_q < win_top_q);
	assign after_pix = (act_q == mfrw_pkg::ACT_WIN_BYTE) ? S_WBIT : S_FIN;

	// pixel mapper feeds from the item or from the window cursor
	always_comb begin
		pix_load = 1'b0;
		pix_x    = col;
		pix_y    = row;
		if (accept && action == mfrw_pkg::ACT_SET_PIXEL) begin
			pix_load = 1'b1;
		end else if (state_q == S_WBIT) begin
			pix_load = 1'b1;
			pix_x    = cur_col_q;
			pix_y    = cur_row_q;
		end
	end

	mfrw_pix_unit u_pix (
		.clk  (clk),
		.load (pix_load),
		.x    (pix_x),
		.y    (pix_y),
		.pix  (pix)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q   <= '0;
			win_top_q    <= '0;
			win_right_q  <= '0;
			win_bottom_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mfrw_pkg::REG_WIN_LEFT:   win_left_q   <= cfg_wdata;
				mfrw_pkg::REG_WIN_TOP:    win_top_q    <= cfg_wdata;
				mfrw_pkg::REG_WIN_RIGHT:  win_right_q  <= cfg_wdata;
				mfrw_pkg::REG_WIN_BOTTOM: win_bottom_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			act_q         <= '0;
			rd_ok_q       <= 1'b0;
			bit_cnt_q     <= '0;
			fill_cnt_q    <= '0;
			cur_col_q     <= '0;
			cur_row_q     <= '0;
			passed_q      <= 1'b0;
			done_q        <= 1'b0;
			read_data_q   <= '0;
			window_done_q <= 1'b0;
		end else begin
			done_q <= (state_q == S_FIN);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q   <= action;
						rd_ok_q <= 1'b0;
						case (action)
							mfrw_pkg::ACT_SET_PIXEL: state_q <= S_PIX;
							mfrw_pkg::ACT_BEGIN_WIN: begin
								cur_col_q <= win_left_q;
								cur_row_q <= win_top_q;
								passed_q  <= 1'b0;
								state_q   <= S_FIN;
							end
							mfrw_pkg::ACT_WIN_BYTE: begin
								bit_cnt_q <= '0;
								state_q   <= win_empty ? S_FIN : S_WBIT;
							end
							mfrw_pkg::ACT_FILL: begin
								fill_cnt_q <= '0;
								state_q    <= S_FILL;
							end
							mfrw_pkg::ACT_READ: begin
								if ({1'b0, byte_addr} <
								    (mfrw_pkg::ADDR_W + 1)'(mfrw_pkg::FRAME_BYTES)) begin
									rd_ok_q <= 1'b1;
									state_q <= S_RD;
								end else begin
									state_q <= S_FIN;
								end
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_PIX: begin
					state_q <= pix.onscreen ? S_RD : after_pix;
				end
				S_RD: begin
					state_q <= (act_q == mfrw_pkg::ACT_READ) ? S_FIN : S_WR;
				end
				S_WR: begin
					state_q <= after_pix;
				end
				S_WBIT: begin
					if (passed_q || bit_cnt_q == 4'd8) begin
						state_q <= S_FIN;
					end else begin
						// cursor position goes to the mapper now; step it
						bit_cnt_q <= bit_cnt_q + 4'd1;
						if (cur_col_q == win_right_q) begin
							cur_col_q <= win_left_q;
							if (cur_row_q == win_bottom_q) begin
								passed_q <= 1'b1;
							end else begin
								cur_row_q <= cur_row_q + CW'(1);
							end
						end else begin
							cur_col_q <= cur_col_q + CW'(1);
						end
						state_q <= S_PIX;
					end
				end
				S_FILL: begin
					fill_cnt_q <= fill_cnt_q + AW'(1);
					if (fill_cnt_q == AW'(mfrw_pkg::FRAME_BYTES - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					read_data_q   <= rd_ok_q ? rdata_q : '0;
					window_done_q <= passed_q || win_empty;
					state_q       <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload and bitmap shifter
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= value;
			shift_q <= value;
			raddr_q <= byte_addr[AW-1:0];
			on_q    <= (value != '0);
		end else if (state_q == S_WBIT) begin
			on_q    <= shift_q[DW-1];
			shift_q <= {shift_q[DW-2:0], 1'b0};
		end
	end

	// frame memory: one write and one registered read port
	always_comb begin
		mem_we    = (state_q == S_WR) || (state_q == S_FILL);
		mem_waddr = (state_q == S_FILL) ? fill_cnt_q : pix.addr;
		mem_wdata = (state_q == S_FILL) ? value_q :
		            (on_q ? (rdata_q | pix.mask) : (rdata_q & ~pix.mask));
		mem_raddr = (act_q == mfrw_pkg::ACT_READ) ? raddr_q : pix.addr;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == S_RD) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	assign done        = done_q;
	assign read_data   = read_data_q;
	assign window_done = window_done_q;

	// checks
	`MFRW_ASSERT_NEXT(a_done_single, clk, arst_n, done_q, !done_q,
		"done held longer than one cycle")
	`MFRW_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy,
		"accepted item did not raise busy")
	`MFRW_ASSERT_NOW(a_bit_cnt_range, clk, arst_n, state_q == S_WBIT, bit_cnt_q <= 4'd8,
		"window bit count beyond one byte")
	`MFRW_ASSERT_NOW(a_read_only, clk, arst_n, done_q && read_data_q != '0,
		act_q == mfrw_pkg::ACT_READ, "read data on a non-read item")
	`MFRW_ASSERT_NOW(a_fill_range, clk, arst_n, state_q == S_FILL,
		{1'b0, fill_cnt_q} < (AW + 1)'(mfrw_pkg::FRAME_BYTES), "fill address past frame")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the mono framebuffer remap writer. A directed list
// covers reads at the frame limits, off-screen pixels, spare action codes and
// a single-pixel window. Random phases then reprogram the window and stream
// bitmap bytes, pixels, reads and fills. Results are checked against a shadow
// frame and cursor kept in the bench, or against the table for typed rows.
// ----------------------------------------------------------------------------

module testbench;
	import mfrw_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int RAND_ITEMS  = 900;
	localparam int QUIET_ITEMS = 100;
	localparam int MAX_FILLS   = 6;
	localparam int DIR_ROWS    = 25;

	// action codes the block must ignore
	localparam logic [ACT_W-1:0] ACT_SPARE_LO  = 3'd5;
	localparam logic [ACT_W-1:0] ACT_SPARE_MID = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_HI  = 3'd7;

	typedef enum int {
		WIN_FULL, WIN_EMPTY, WIN_SINGLE, WIN_CORNER, WIN_EDGE, WIN_ROW, WIN_SMALL
	} win_shape_t;

	typedef struct packed {
		logic [ACT_W-1:0]   act;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [DATA_W-1:0]  val;
		logic [ADDR_W-1:0]  addr;
	} frame_cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] rd;
		logic              wd;
	} frame_res_t;

	typedef struct packed {
		logic [ACT_W-1:0]   act;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [DATA_W-1:0]  val;
		logic [ADDR_W-1:0]  addr;
		logic               typed;
		logic [DATA_W-1:0]  exp_rd;
		logic               exp_wd;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [ACT_W-1:0] action;
	logic [COORD_W-1:0] col;
	logic [COORD_W-1:0] row;
	logic [DATA_W-1:0] value;
	logic [ADDR_W-1:0] byte_addr;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [COORD_W-1:0] cfg_wdata;
	logic done;
	logic [DATA_W-1:0] read_data;
	logic window_done;

	// shadow of the frame memory, cursor and window registers
	logic [DATA_W-1:0] frame_img [FRAME_BYTES];
	logic [COORD_W-1:0] win_reg [4];
	logic [COORD_W-1:0] cur_col;
	logic [COORD_W-1:0] cur_row;
	bit win_passed;
	int unsigned last_touched;

	frame_res_t expected_frame_out [$];
	int mismatches = 0;
	int items_sent = 0;
	int fills_left = MAX_FILLS;

	mono_framebuffer_remap_writer_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.col         (col),
		.row         (row),
		.value       (value),
		.byte_addr   (byte_addr),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.read_data   (read_data),
		.window_done (window_done)
	);

	always #HALF_PERIOD clk = ~clk;

	// landscape packing: column pairs by inverted row quads
	function automatic int unsigned pixel_index(int unsigned x, int unsigned y);
		return (x / 2) * ROW_BYTES + (VERT_RES - 1 - y) / 4;
	endfunction

	function automatic void paint_pixel(int unsigned x, int unsigned y, bit on);
		int unsigned iy;
		int unsigned idx;
		logic [DATA_W-1:0] m;
		if (x >= HORIZ_RES || y >= VERT_RES)
			return;
		iy = VERT_RES - 1 - y;
		idx = pixel_index(x, y);
		m = 8'h80 >> (((iy % 4) * 2) + (x % 2));
		frame_img[idx] = on ? (frame_img[idx] | m) : (frame_img[idx] & ~m);
		last_touched = idx;
	endfunction

	function automatic bit window_empty();
		return win_reg[REG_WIN_RIGHT] < win_reg[REG_WIN_LEFT] ||
			win_reg[REG_WIN_BOTTOM] < win_reg[REG_WIN_TOP];
	endfunction

	// apply one action to the shadow state, return the byte and window status
	function automatic frame_res_t frame_step(frame_cmd_t c);
		frame_res_t res;
		int i;
		res.rd = '0;
		case (c.act)
		ACT_SET_PIXEL: paint_pixel(c.col, c.row, c.val != '0);
		ACT_BEGIN_WIN: begin
			cur_col = win_reg[REG_WIN_LEFT];
			cur_row = win_reg[REG_WIN_TOP];
			win_passed = 1'b0;
		end
		ACT_WIN_BYTE: if (!window_empty()) begin
			// MSB first, raster order, stop once the last pixel is done
			for (i = 0; i < 8 && !win_passed; i++) begin
				paint_pixel(cur_col, cur_row, c.val[7 - i]);
				if (cur_col == win_reg[REG_WIN_RIGHT]) begin
					cur_col = win_reg[REG_WIN_LEFT];
					if (cur_row == win_reg[REG_WIN_BOTTOM])
						win_passed = 1'b1;
					else
						cur_row = cur_row + 1'b1;
				end else begin
					cur_col = cur_col + 1'b1;
				end
			end
		end
		ACT_FILL: foreach (frame_img[k]) frame_img[k] = c.val;
		ACT_READ: if (c.addr < FRAME_BYTES) res.rd = frame_img[c.addr];
		default: ;
		endcase
		res.wd = win_passed || window_empty();
		return res;
	endfunction

	function automatic frame_cmd_t random_cmd();
		frame_cmd_t c;
		c.act = ACT_W'($urandom_range(0, 7));
		c.col = COORD_W'($urandom_range(0, 511));
		c.row = COORD_W'($urandom_range(0, 511));
		c.val = DATA_W'($urandom_range(0, 255));
		c.addr = ADDR_W'($urandom_range(0, 16383));
		return c;
	endfunction

	// drive one item and wait for it to be taken; start stays high on return
	task automatic send_item(frame_cmd_t c, bit typed, frame_res_t typed_res);
		frame_res_t res;
		action <= c.act;
		col <= c.col;
		row <= c.row;
		value <= c.val;
		byte_addr <= c.addr;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		res = frame_step(c);
		expected_frame_out.push_back(typed ? typed_res : res);
		if (c.act <= ACT_READ)
			items_sent++;
	endtask

	// occasional sender gap, none near the end of the run
	task automatic random_gap();
		if (items_sent < RAND_ITEMS - QUIET_ITEMS && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// hold off until every pending result is back and the block is idle
	task automatic drain();
		start <= 1'b0;
		while (expected_frame_out.size() != 0 || busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic program_window(int l, int t, int r, int b, logic [3:0] sel);
		logic [COORD_W-1:0] vals [4];
		int k;
		vals[REG_WIN_LEFT] = COORD_W'(l);
		vals[REG_WIN_TOP] = COORD_W'(t);
		vals[REG_WIN_RIGHT] = COORD_W'(r);
		vals[REG_WIN_BOTTOM] = COORD_W'(b);
		for (k = 0; k < 4; k++)
			if (sel[k]) begin
				cfg_we <= 1'b1;
				cfg_index <= 2'(k);
				cfg_wdata <= vals[k];
				win_reg[k] = vals[k];
				@(posedge clk);
			end
		cfg_we <= 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin : check_result
		frame_res_t want;
		if (arst_n && done) begin
			if (expected_frame_out.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result with nothing pending: read_data=%02h window_done=%0b",
						$time, read_data, window_done);
				mismatches++;
			end else begin
				want = expected_frame_out.pop_front();
				if (read_data !== want.rd || window_done !== want.wd) begin
					if (mismatches < 10)
						$display("%0t: mismatch: read_data %02h/%02h window_done %0b/%0b (exp/got)",
							$time, want.rd, read_data, want.wd, window_done);
					mismatches++;
				end
			end
		end
	end

	// stimulus
	initial begin
		frame_cmd_t c;
		frame_res_t typed_res;
		dir_row_t dir_rows [DIR_ROWS];
		win_shape_t shape;
		logic [3:0] sel;
		int l, t, r, b;
		int phase, n, pick;

		arst_n <= 1'b0;
		start <= 1'b0;
		action <= ACT_SET_PIXEL;
		col <= '0;
		row <= '0;
		value <= '0;
		byte_addr <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_WIN_LEFT;
		cfg_wdata <= '0;
		foreach (win_reg[k]) win_reg[k] = '0;
		cur_col = '0;
		cur_row = '0;
		win_passed = 1'b0;
		last_touched = 0;
		typed_res = '0;

		// act, col, row, value, addr, typed, read_data, window_done
		dir_rows = '{
			'{ACT_FILL, 9'd0, 9'd0, 8'hA5, 14'd0, 1'b1, 8'h00, 1'b0},
			'{ACT_READ, 9'd0, 9'd0, 8'h00, 14'd0, 1'b1, 8'hA5, 1'b0},
			'{ACT_READ, 9'd0, 9'd0, 8'h00, 14'(FRAME_BYTES - 1), 1'b1, 8'hA5, 1'b0},
			'{ACT_READ, 9'd0, 9'd0, 8'h00, 14'(FRAME_BYTES), 1'b1, 8'h00, 1'b0},
			'{ACT_READ, 9'd0, 9'd0, 8'h00, 14'h3FFF, 1'b1, 8'h00, 1'b0},
			'{ACT_SET_PIXEL, 9'd0, 9'd0, 8'h00, 14'd0, 1'b0, 8'h00, 1'b0},
			'{ACT_SET_PIXEL, 9'd399, 9'd299, 8'hFF, 14'd0, 1'b0, 8'h00, 1'b0},
			'{ACT_SET_PIXEL, 9'd400, 9'd0, 8'h01, 14'd0, 1'b0, 8'h00, 1'b0},
			'{ACT_SET_PIXEL, 9'd0, 9'd300, 8'h01, 14'd0, 1'b0, 8'h00, 1'b0},
			'{ACT_SET_PIXEL, 9'd511, 9'd511, 8'hFF, 14'd0, 1'b0, 8'h00, 1'b0},
			'{ACT_READ, 9'd0, 9'd0, 8'h00, 14'(pixel_index(0, 0)), 1'b0, 8'h00, 1'b0},
			'{ACT_READ, 9'd0, 9'd0, 8'h00, 14'(pixel_index(399, 299)), 1'b0, 8'h00, 1'b0},
			'{ACT_SPARE_LO, 9'd0, 9'd0, 8'h00, 14'd0, 1'b1, 8'h00, 1'b0},
			'{ACT_SPARE_MID, 9'd0, 9'd0, 8'h00, 14'd0, 1'b1, 8'h00, 1'b0},
			'{ACT_SPARE_HI, 9'd511, 9'd511, 8'hFF, 14'h3FFF, 1'b1, 8'h00, 1'b0},
			'{ACT_WIN_BYTE, 9'd0, 9'd0, 8'h80, 14'd0, 1'b0, 8'h00, 1'b0},
			'{ACT_READ, 9'd0, 9'd0, 8'h00, 14'(pixel_index(0, 0)), 1'b0, 8'h00, 1'b0},
			'{ACT_BEGIN_WIN, 9'd0, 9'd0, 8'h00, 14'd0, 1'b1, 8'h00, 1'b0},
			'{ACT_WIN_BYTE, 9'd0, 9'd0, 8'h00, 14'd0, 1'b0, 8'h00, 1'b0},
			'{ACT_WIN_BYTE, 9'd0, 9'd0, 8'hFF, 14'd0, 1'b0, 8'h00, 1'b0},
			'{ACT_READ, 9'd0, 9'd0, 8'h00, 14'(pixel_index(0, 0)), 1'b0, 8'h00, 1'b0},
			'{ACT_SET_PIXEL, 9'd1, 9'd298, 8'h80, 14'd0, 1'b0, 8'h00, 1'b0},
			'{ACT_READ, 9'd0, 9'd0, 8'h00, 14'(pixel_index(1, 298)), 1'b0, 8'h00, 1'b0},
			'{ACT_FILL, 9'd0, 9'd0, 8'h5A, 14'd0, 1'b0, 8'h00, 1'b0},
			'{ACT_READ, 9'd0, 9'd0, 8'h00, 14'(pixel_index(1, 298)), 1'b0, 8'h00, 1'b0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed list, reset window (single pixel at the origin)
		foreach (dir_rows[i]) begin
			c.act = dir_rows[i].act;
			c.col = dir_rows[i].col;
			c.row = dir_rows[i].row;
			c.val = dir_rows[i].val;
			c.addr = dir_rows[i].addr;
			typed_res.rd = dir_rows[i].exp_rd;
			typed_res.wd = dir_rows[i].exp_wd;
			send_item(c, dir_rows[i].typed, typed_res);
			random_gap();
		end

		// random phases, each with its own window
		items_sent = 0;
		phase = 0;
		while (items_sent < RAND_ITEMS) begin
			drain();
			pick = $urandom_range(0, 9);
			shape = (phase < 4) ? win_shape_t'(phase) :
				(pick >= WIN_SMALL) ? WIN_SMALL : win_shape_t'(pick);
			case (shape)
			WIN_FULL: begin
				l = 0; t = 0; r = 511; b = 511;
			end
			WIN_EMPTY: begin
				l = $urandom_range(0, 511);
				r = $urandom_range(0, 511);
				t = $urandom_range(0, 511);
				b = $urandom_range(0, 511);
				if ($urandom_range(0, 1) == 0) begin
					l = $urandom_range(1, 511);
					r = $urandom_range(0, l - 1);
				end else begin
					t = $urandom_range(1, 511);
					b = $urandom_range(0, t - 1);
				end
			end
			WIN_SINGLE: begin
				l = $urandom_range(0, HORIZ_RES - 1);
				r = l;
				t = $urandom_range(0, VERT_RES - 1);
				b = t;
			end
			WIN_CORNER: begin
				// entirely off-screen at the top of the register range
				l = $urandom_range(500, 511);
				r = 511;
				t = $urandom_range(504, 511);
				b = 511;
			end
			WIN_EDGE: begin
				// straddles the right and bottom borders
				l = $urandom_range(HORIZ_RES - 20, HORIZ_RES - 1);
				r = l + $urandom_range(0, 40);
				t = $urandom_range(VERT_RES - 20, VERT_RES - 1);
				b = t + $urandom_range(0, 20);
			end
			WIN_ROW: begin
				l = 0;
				r = HORIZ_RES - 1;
				t = $urandom_range(0, VERT_RES - 1);
				b = t;
			end
			default: begin
				l = $urandom_range(0, HORIZ_RES - 1);
				r = l + $urandom_range(0, 23);
				t = $urandom_range(0, VERT_RES - 1);
				b = t + $urandom_range(0, 11);
			end
			endcase
			sel = (phase == 0 || $urandom_range(0, 3) != 0) ? 4'hF : 4'($urandom_range(1, 15));
			program_window(l, t, r, b, sel);

			// sometimes keep the old cursor so it runs outside the new window
			if (phase == 0 || $urandom_range(0, 3) != 0) begin
				c = random_cmd();
				c.act = ACT_BEGIN_WIN;
				send_item(c, 1'b0, typed_res);
				random_gap();
			end

			n = $urandom_range(12, 48);
			repeat (n) begin
				c = random_cmd();
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					c.act = ACT_WIN_BYTE;
				end else if (pick < 67) begin
					c.act = ACT_SET_PIXEL;
					if (pick < 64) begin
						c.col = COORD_W'($urandom_range(0, HORIZ_RES - 1));
						c.row = COORD_W'($urandom_range(0, VERT_RES - 1));
					end
					if (pick % 3 == 0)
						c.val = '0;
				end else if (pick < 85) begin
					c.act = ACT_READ;
					if (pick < 76)
						c.addr = ADDR_W'(last_touched);
					else if (pick < 83)
						c.addr = ADDR_W'($urandom_range(0, FRAME_BYTES - 1));
				end else if (pick < 90) begin
					c.act = ACT_BEGIN_WIN;
				end else if (pick < 93) begin
					c.act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
				end else if (pick == 93 && fills_left > 0) begin
					c.act = ACT_FILL;
					fills_left--;
				end else begin
					c.act = ACT_READ;
				end
				send_item(c, 1'b0, typed_res);
				random_gap();
			end
			phase++;
		end

		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_frame_out.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#(30_000_000);
		$display("testbench: FAIL");
		$finish;
	end

endmodule
